// File: design/plti_pkg.sv
// Package for the piecewise linear table interpolation unit.
// Holds the knot tables, widths and table read functions; no dependencies.
package plti_pkg;

	localparam int TABLE_POINTS = 91;
	localparam int ENERGY_W = 24;
	localparam int DAMAGE_W = 17;
	localparam int FRAC_W = 16;
	localparam int IDX_W = $clog2(TABLE_POINTS);

	localparam logic [ENERGY_W-1:0] KNOT_E [TABLE_POINTS] = '{
		24'd102, 24'd154, 24'd205, 24'd256, 24'd307, 24'd358, 24'd410, 24'd461,
		24'd512, 24'd563, 24'd614, 24'd666, 24'd717, 24'd768, 24'd819, 24'd870,
		24'd922, 24'd973, 24'd1024, 24'd1536, 24'd2048, 24'd2560, 24'd3072,
		24'd3584, 24'd4096, 24'd4608, 24'd5120, 24'd5632, 24'd6144, 24'd6656,
		24'd7168, 24'd7680, 24'd8192, 24'd8704, 24'd9216, 24'd9728, 24'd10240,
		24'd15360, 24'd20480, 24'd25600, 24'd30720, 24'd35840, 24'd40960,
		24'd46080, 24'd51200, 24'd56320, 24'd61440, 24'd66560, 24'd71680,
		24'd76800, 24'd81920, 24'd87040, 24'd92160, 24'd97280, 24'd102400,
		24'd153600, 24'd204800, 24'd256000, 24'd307200, 24'd358400, 24'd409600,
		24'd460800, 24'd512000, 24'd563200, 24'd614400, 24'd665600, 24'd716800,
		24'd768000, 24'd819200, 24'd870400, 24'd921600, 24'd972800, 24'd1024000,
		24'd1536000, 24'd2048000, 24'd2560000, 24'd3072000, 24'd3584000,
		24'd4096000, 24'd4608000, 24'd5120000, 24'd5632000, 24'd6144000,
		24'd6656000, 24'd7168000, 24'd7680000, 24'd8192000, 24'd8704000,
		24'd9216000, 24'd9728000, 24'd10240000
	};

	localparam logic [DAMAGE_W-1:0] KNOT_V [TABLE_POINTS] = '{
		17'd0, 17'd0, 17'd0, 17'd1276, 17'd3013, 17'd4398, 17'd5571, 17'd6606,
		17'd7542, 17'd8403, 17'd9208, 17'd9966, 17'd10684, 17'd11368, 17'd12023,
		17'd12652, 17'd13256, 17'd13839, 17'd14403, 17'd19207, 17'd22966,
		17'd26052, 17'd28660, 17'd30915, 17'd32895, 17'd34657, 17'd36242,
		17'd37680, 17'd38995, 17'd40203, 17'd41321, 17'd42359, 17'd43327,
		17'd44234, 17'd45085, 17'd45888, 17'd46645, 17'd52460, 17'd56316,
		17'd59075, 17'd61139, 17'd62720, 17'd63956, 17'd64934, 17'd65711,
		17'd66339, 17'd66844, 17'd67255, 17'd67590, 17'd67863, 17'd68089,
		17'd68280, 17'd68434, 17'd68558, 17'd68666, 17'd69124, 17'd69191,
		17'd69176, 17'd69145, 17'd69109, 17'd69078, 17'd69047, 17'd69021,
		17'd69001, 17'd68980, 17'd68965, 17'd68949, 17'd68934, 17'd68923,
		17'd68913, 17'd68903, 17'd68893, 17'd68882, 17'd68831, 17'd68800,
		17'd68784, 17'd68769, 17'd68764, 17'd68754, 17'd68748, 17'd68743,
		17'd68743, 17'd68738, 17'd68738, 17'd68733, 17'd68733, 17'd68733,
		17'd68728, 17'd68728, 17'd68728, 17'd68728
	};

	// out of range index reads as all ones (energy) / zero (value)
	function automatic logic [ENERGY_W-1:0] knot_e(input logic [IDX_W:0] i);
		logic [ENERGY_W-1:0] r;
		r = '1;
		if (int'(i) < TABLE_POINTS) r = KNOT_E[i[IDX_W-1:0]];
		return r;
	endfunction

	function automatic logic [DAMAGE_W-1:0] knot_v(input logic [IDX_W:0] i);
		logic [DAMAGE_W-1:0] r;
		r = '0;
		if (int'(i) < TABLE_POINTS) r = KNOT_V[i[IDX_W-1:0]];
		return r;
	endfunction

	typedef struct packed {
		logic                vld;
		logic                clamp;
		logic [DAMAGE_W-1:0] res;
		logic [ENERGY_W-1:0] e;
		logic [IDX_W-1:0]    pos;
		logic [ENERGY_W-1:0] rem;
		logic [ENERGY_W-1:0] den;
		logic [FRAC_W-1:0]   quo;
		logic [DAMAGE_W-1:0] vlo;
		logic [DAMAGE_W-1:0] dv;
		logic                neg;
		logic [FRAC_W+DAMAGE_W-1:0] prod;
	} stage_t;

endpackage

// File: design/piecewise_linear_table_interp_unit.sv
// Top level of the piecewise linear table interpolation unit.
// Maps energy words to damage words; depends on plti_pkg.
//
// Usage:
//   Input channel: energy with in_valid / in_stall. Output channel: damage
//   with out_valid / out_stall. A word moves when valid is high and stall low.
//   Every energy word gives exactly one damage word, in order.
// Pipeline: one capture stage, one stage per bit of the knot binary search,
//   one for interval setup, one per quotient bit of the 16-step restoring
//   divider, a multiply stage of its own, final add.
// Throughput: one word per cycle unless out_stall freezes the pipe; a search
//   stage is a table read and compare, a divider stage a compare-subtract.
// Reset: arst_n clears all stage valid bits; the pipe comes up empty.
// Stall: when out_stall holds a valid output, the whole pipe freezes and
//   in_stall is raised in the same cycle; nothing is dropped or repeated.
module piecewise_linear_table_interp_unit
	import plti_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [ENERGY_W-1:0] energy,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [DAMAGE_W-1:0] damage
);

	localparam int SRCH0 = 1;
	localparam int SETUP = SRCH0 + IDX_W;
	localparam int DIV0  = SETUP + 1;
	localparam int MULT  = DIV0 + FRAC_W;
	localparam int FIN   = MULT + 1;
	localparam int DEPTH = FIN + 1;

	stage_t stg_s [DEPTH];
	stage_t nxt [DEPTH];
	logic   en;

	assign en = !(stg_s[DEPTH-1].vld && out_stall);
	assign in_stall = !en;

	always_comb begin
		nxt[0] = stg_s[0];
		nxt[0].vld = in_valid;
		nxt[0].e = energy;
		nxt[0].pos = '0;
		nxt[0].clamp = 1'b0;
		nxt[0].res = '0;
		if (energy <= KNOT_E[0]) begin
			nxt[0].clamp = 1'b1;
			nxt[0].res = KNOT_V[0];
		end else if (energy >= KNOT_E[TABLE_POINTS-1]) begin
			nxt[0].clamp = 1'b1;
			nxt[0].res = KNOT_V[TABLE_POINTS-1];
		end
	end

	genvar k;
	generate
		for (k = 1; k < DEPTH; k++) begin : g_stage
			if (k < SETUP) begin : g_srch
				localparam int B = IDX_W - k;
				always_comb begin
					logic [IDX_W:0] cand;
					nxt[k] = stg_s[k-1];
					cand = {1'b0, stg_s[k-1].pos} | ((IDX_W+1)'(1) << B);
					if (knot_e(cand) <= stg_s[k-1].e) nxt[k].pos = cand[IDX_W-1:0];
				end
			end else if (k == SETUP) begin : g_setup
				always_comb begin
					logic [IDX_W:0]      lo;
					logic [IDX_W:0]      hi;
					logic [DAMAGE_W-1:0] vhi;
					nxt[k] = stg_s[k-1];
					lo = {1'b0, stg_s[k-1].pos};
					hi = lo + 1'b1;
					vhi = knot_v(hi);
					nxt[k].rem = stg_s[k-1].e - knot_e(lo);
					nxt[k].den = knot_e(hi) - knot_e(lo);
					nxt[k].vlo = knot_v(lo);
					nxt[k].neg = vhi < knot_v(lo);
					nxt[k].dv = (vhi < knot_v(lo)) ? knot_v(lo) - vhi : vhi - knot_v(lo);
					nxt[k].quo = '0;
				end
			end else if (k < MULT) begin : g_div
				always_comb begin
					logic [ENERGY_W:0] r2;
					nxt[k] = stg_s[k-1];
					r2 = {stg_s[k-1].rem, 1'b0};
					nxt[k].quo = {stg_s[k-1].quo[FRAC_W-2:0], 1'b0};
					if (r2 >= {1'b0, stg_s[k-1].den}) begin
						nxt[k].rem = ENERGY_W'(r2 - {1'b0, stg_s[k-1].den});
						nxt[k].quo[0] = 1'b1;
					end else begin
						nxt[k].rem = r2[ENERGY_W-1:0];
					end
				end
			end else if (k == MULT) begin : g_mult
				always_comb begin
					nxt[k] = stg_s[k-1];
					nxt[k].prod = stg_s[k-1].quo * stg_s[k-1].dv;
				end
			end else begin : g_fin
				always_comb begin
					logic [FRAC_W+DAMAGE_W:0] up;
					nxt[k] = stg_s[k-1];
					up = {1'b0, stg_s[k-1].prod} + (FRAC_W+DAMAGE_W+1)'(16'hFFFF);
					if (!stg_s[k-1].clamp) begin
						if (stg_s[k-1].neg)
							nxt[k].res = stg_s[k-1].vlo - up[FRAC_W+DAMAGE_W-1:FRAC_W];
						else
							nxt[k].res = stg_s[k-1].vlo
								+ stg_s[k-1].prod[FRAC_W+DAMAGE_W-1:FRAC_W];
					end
				end
			end
		end

		for (k = 0; k < DEPTH; k++) begin : g_reg
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					stg_s[k] <= '0;
				end else if (en) begin
					stg_s[k] <= nxt[k];
				end
			end
		end
	endgenerate

	assign out_valid = stg_s[DEPTH-1].vld;
	assign damage = stg_s[DEPTH-1].res;

endmodule
